// File: hw/rtl/itoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  // Field widths
  localparam int VALUE_W = 17;
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 5;

  // Defaults
  localparam int MAG_WIDTH = 16;
  localparam int MAX_OUT   = 16;

  // Radix limits and reset value
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd32;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'd65;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 5'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Stack control from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  // Map one digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = {3'b000, d};
    if (d >= DIGIT_TEN) begin
      return CHAR_UPPER + dw - {3'b000, DIGIT_TEN};
    end
    return CHAR_ZERO + dw;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/itoa_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial restoring divider: one quotient bit per cycle
module itoa_div #(
  parameter int MAG_WIDTH = itoa_pkg::MAG_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [MAG_WIDTH-1:0]           dividend,
  input  wire logic [itoa_pkg::RADIX_W-1:0]   divisor,
  output logic                                done,
  output logic [MAG_WIDTH-1:0]                quotient,
  output logic [itoa_pkg::DIGIT_W-1:0]        remainder
);

  localparam int CW = (MAG_WIDTH > 1) ? $clog2(MAG_WIDTH) : 1;
  localparam logic [CW-1:0] LAST_STEP = CW'(MAG_WIDTH - 1);

  logic                         busy;
  logic [CW-1:0]                cnt;
  logic [itoa_pkg::RADIX_W-1:0] trial;
  logic                         fits;
  logic [itoa_pkg::DIGIT_W-1:0] remainder_next;

  // Shift one dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial          = {remainder, quotient[MAG_WIDTH-1]};
    fits           = (trial >= divisor);
    remainder_next = fits ? itoa_pkg::DIGIT_W'(trial - divisor)
                          : trial[itoa_pkg::DIGIT_W-1:0];
  end

  // Control: load on start, count steps, flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits enter at the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[MAG_WIDTH-2:0], fits};
      remainder <= remainder_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/itoa_stack.sv
`timescale 1ns / 1ps
`default_nettype none

// Character stack as a shift register: push and pop both at entry 0
module itoa_stack #(
  parameter int DEPTH = itoa_pkg::MAX_OUT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire itoa_pkg::stk_ctrl_t           ctrl,
  input  wire logic [itoa_pkg::CHAR_W-1:0]   push_char,
  output logic [itoa_pkg::CHAR_W-1:0]        top_char,
  output logic [$clog2(DEPTH+1)-1:0]         count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [itoa_pkg::CHAR_W-1:0] entries [DEPTH];
  logic                        full;

  assign full     = (count == CNT_W'(DEPTH));
  assign top_char = entries[0];

  // Track fill level; drop pushes once full so the low digits are kept
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.push && !full) begin
      count <= count + 1'b1;
    end else if (ctrl.pop && count != '0) begin
      count <= count - 1'b1;
    end
  end

  // Shift entries down on push, up on pop
  always_ff @(posedge clk) begin
    if (ctrl.push && !full) begin
      entries[0] <= push_char;
      for (int i = 1; i < DEPTH; i++) begin
        entries[i] <= entries[i-1];
      end
    end else if (ctrl.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        entries[i] <= entries[i+1];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("stack count above depth");

  a_push_full_holds: assert property (@(posedge clk) disable iff (rst)
    (full && ctrl.push) |=> count == CNT_W'(DEPTH))
    else $error("push into full stack changed count");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (ctrl.pop && !ctrl.push && count != '0) |=> count == $past(count) - 1'b1)
    else $error("pop did not decrement count");

endmodule

`default_nettype wire

// File: hw/rtl/integer_to_ascii_digits.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts a signed 17-bit integer to its ASCII digit string in a set radix.
// Input channel: value with item_valid / item_stall; a beat is taken when
// item_valid is high and item_stall is low. item_stall is high from the
// accepting edge until the last character of that string has been taken.
// Output channel: character and last with char_valid / char_stall; one beat
// per character, most significant first, last high on the final one. The
// characters sit in a register stack, so char_stall simply holds the current
// beat for as long as the receiver needs.
// Config: radix written through cfg_valid / cfg_ready (ready is always high);
// write it only while no string is in flight. A radix outside 2..32 makes
// an accepted value produce no characters.
// Sequencing: each digit takes one pass of the bit-serial divider, then a
// sign step follows (a zero magnitude goes straight to it); the string then
// drains at one character per cycle while char_stall is low. A new value is
// taken only once the last character of the string has drained.
// Reset: synchronous; radix returns to 10 and any string in flight is dropped.
module integer_to_ascii_digits #(
  parameter int MAG_WIDTH = itoa_pkg::MAG_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // config
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [itoa_pkg::RADIX_W-1:0]        radix,
  // input beats
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire logic signed [itoa_pkg::VALUE_W-1:0] value,
  // output beats
  output logic                                     char_valid,
  input  wire logic                                char_stall,
  output logic [itoa_pkg::CHAR_W-1:0]              character,
  output logic                                     last
);

  localparam int DEPTH = itoa_pkg::MAX_OUT;
  localparam int CNT_W = $clog2(DEPTH + 1);

  itoa_pkg::state_t state, state_next;

  logic [itoa_pkg::RADIX_W-1:0] base;
  logic                         minus;
  logic                         radix_ok;
  logic                         accept;
  logic [itoa_pkg::VALUE_W-1:0] raw;
  logic [itoa_pkg::VALUE_W-1:0] abs_val;
  logic [MAG_WIDTH-1:0]         mag_in;
  logic                         mag_zero;

  logic                         div_start;
  logic                         div_done;
  logic [MAG_WIDTH-1:0]         dividend;
  logic [MAG_WIDTH-1:0]         quotient;
  logic [itoa_pkg::DIGIT_W-1:0] remainder;

  itoa_pkg::stk_ctrl_t          stk_ctrl;
  logic [itoa_pkg::CHAR_W-1:0]  push_char;
  logic [CNT_W-1:0]             count;

  assign cfg_ready = 1'b1;

  // Hold the radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= itoa_pkg::RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base <= radix;
    end
  end

  assign radix_ok = base inside {[itoa_pkg::RADIX_MIN:itoa_pkg::RADIX_MAX]};
  assign accept   = item_valid && !item_stall;

  // Take the magnitude and fit it to MAG_WIDTH bits
  assign raw     = value;
  assign abs_val = raw[itoa_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;

  generate
    if (MAG_WIDTH <= itoa_pkg::VALUE_W) begin : g_trunc
      assign mag_in = abs_val[MAG_WIDTH-1:0];
    end else begin : g_ext
      assign mag_in = {{(MAG_WIDTH - itoa_pkg::VALUE_W){1'b0}}, abs_val};
    end
  endgenerate

  assign mag_zero = (mag_in == '0);
  assign dividend = (state == itoa_pkg::ST_IDLE) ? mag_in : quotient;

  // Remember whether this string needs a leading minus
  always_ff @(posedge clk) begin
    if (accept) begin
      minus <= raw[itoa_pkg::VALUE_W-1] && (base == itoa_pkg::RADIX_DEC);
    end
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      itoa_pkg::ST_IDLE: begin
        if (item_valid && radix_ok) begin
          state_next = mag_zero ? itoa_pkg::ST_SIGN : itoa_pkg::ST_DIV;
        end
      end
      itoa_pkg::ST_DIV: begin
        if (div_done && quotient == '0) begin
          state_next = itoa_pkg::ST_SIGN;
        end
      end
      itoa_pkg::ST_SIGN: begin
        state_next = itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_EMIT: begin
        if (!char_stall && count == CNT_W'(1)) begin
          state_next = itoa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    item_stall    = 1'b1;
    char_valid    = 1'b0;
    div_start     = 1'b0;
    stk_ctrl.push = 1'b0;
    stk_ctrl.pop  = 1'b0;
    push_char     = itoa_pkg::CHAR_ZERO;
    case (state)
      itoa_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid && radix_ok) begin
          if (mag_zero) begin
            stk_ctrl.push = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      itoa_pkg::ST_DIV: begin
        push_char = itoa_pkg::digit_char(remainder);
        if (div_done) begin
          stk_ctrl.push = 1'b1;
          div_start     = (quotient != '0);
        end
      end
      itoa_pkg::ST_SIGN: begin
        push_char     = itoa_pkg::CHAR_MINUS;
        stk_ctrl.push = minus;
      end
      itoa_pkg::ST_EMIT: begin
        char_valid   = 1'b1;
        stk_ctrl.pop = !char_stall;
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

  itoa_div #(
    .MAG_WIDTH(MAG_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (base),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  itoa_stack #(
    .DEPTH(DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (stk_ctrl),
    .push_char (push_char),
    .top_char  (character),
    .count     (count)
  );

  assign last = (count == CNT_W'(1));

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> count != '0)
    else $error("character offered from empty stack");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == itoa_pkg::ST_DIV)
    else $error("divider finished outside divide state");

  a_bad_radix_idle: assert property (@(posedge clk) disable iff (rst)
    (state == itoa_pkg::ST_IDLE && item_valid && !radix_ok) |=>
      state == itoa_pkg::ST_IDLE)
    else $error("bad radix started a conversion");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == itoa_pkg::ST_IDLE) |-> count == '0)
    else $error("stack not drained at idle");

endmodule

`default_nettype wire

// File: sim/integer_to_ascii_digits_test.sv
`timescale 1ns / 1ps

module integer_to_ascii_digits_test;

  localparam int QUIET_LIMIT   = 5000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 50;
  localparam int TAIL_CYCLES   = 300;

  // One directed row: radix to run under, value, and the string typed in
  // by hand (empty when the digit predictor supplies it).
  typedef struct {
    logic [itoa_pkg::RADIX_W-1:0] base;
    int                           num;
    string                        text;
  } plan_row_t;

  typedef struct {
    logic [itoa_pkg::CHAR_W-1:0] character;
    logic                        last;
  } char_beat_t;

  logic                                clk        = 1'b0;
  logic                                rst        = 1'b1;
  logic                                cfg_valid  = 1'b0;
  logic                                cfg_ready;
  logic [itoa_pkg::RADIX_W-1:0]        radix      = itoa_pkg::RADIX_RESET;
  logic                                item_valid = 1'b0;
  logic                                item_stall;
  logic signed [itoa_pkg::VALUE_W-1:0] value      = '0;
  logic                                char_valid;
  logic                                char_stall = 1'b0;
  logic [itoa_pkg::CHAR_W-1:0]         character;
  logic                                last;

  logic [itoa_pkg::RADIX_W-1:0] model_radix = itoa_pkg::RADIX_RESET;
  string                        strings_typed[$];
  char_beat_t                   chars_due[$];
  int                           items_taken  = 0;
  int                           strings_done = 0;
  int                           errors       = 0;
  int                           quiet_cycles = 0;
  int                           stall_odds   = 0;
  int                           gap_odds     = 0;

  integer_to_ascii_digits uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .radix      (radix),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .value      (value),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .character  (character),
    .last       (last)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // Spell a value in the given radix, most significant character first
  function automatic string spell_value(
      input logic signed [itoa_pkg::VALUE_W-1:0] num,
      input logic [itoa_pkg::RADIX_W-1:0] base);
    logic [itoa_pkg::VALUE_W-1:0]   mag_full;
    logic [itoa_pkg::MAG_WIDTH-1:0] mag;
    logic [itoa_pkg::DIGIT_W-1:0]   d;
    logic [itoa_pkg::CHAR_W-1:0]    ch;
    string                          s;
    s = "";
    mag_full = num[itoa_pkg::VALUE_W-1] ? (~num + 1'b1) : num;
    // keep only the low magnitude bits, so -65536 collapses to zero
    mag = mag_full[itoa_pkg::MAG_WIDTH-1:0];
    while (mag != 0) begin
      d = itoa_pkg::DIGIT_W'(mag % base);
      ch = (d >= itoa_pkg::DIGIT_TEN) ? itoa_pkg::CHAR_UPPER + (d - itoa_pkg::DIGIT_TEN)
                                      : itoa_pkg::CHAR_ZERO + d;
      s = $sformatf("%c%s", ch, s);
      mag = mag / base;
    end
    if (s.len() == 0) begin
      s = $sformatf("%c", itoa_pkg::CHAR_ZERO);
    end
    // sign only in decimal
    if (num[itoa_pkg::VALUE_W-1] && base == itoa_pkg::RADIX_DEC) begin
      s = $sformatf("%c%s", itoa_pkg::CHAR_MINUS, s);
    end
    // an overlong string keeps its least significant characters
    if (s.len() > itoa_pkg::MAX_OUT) begin
      s = s.substr(s.len() - itoa_pkg::MAX_OUT, s.len() - 1);
    end
    return s;
  endfunction

  // Track the radix, queue expected characters, and check each output beat
  always @(posedge clk) begin : watch_beats
    char_beat_t want;
    string      text;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        model_radix = radix;
      end
      if (char_valid && !char_stall) begin
        if (last) begin
          strings_done++;
        end
        if (chars_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected character beat %02h last %b", $time, character, last);
        end else begin
          want = chars_due.pop_front();
          if (character !== want.character) begin
            errors++;
            $display("%0t: character expected %02h actual %02h",
                     $time, want.character, character);
          end
          if (last !== want.last) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, want.last, last);
          end
        end
      end
      if (item_valid && !item_stall) begin
        text = strings_typed.pop_front();
        if (text.len() == 0) begin
          text = spell_value(value, model_radix);
        end
        for (int i = 0; i < text.len(); i++) begin
          want.character = text[i];
          want.last = (i == text.len() - 1);
          chars_due.push_back(want);
        end
      end
    end
  end

  // Count cycles in which no beat moves on any channel
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (char_valid && !char_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
    end
    $display("integer_to_ascii_digits_test: done, errors");
    $finish;
  end

  // Stall the character channel in short random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        char_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        char_stall <= 1'b0;
      end
    end
  end

  // Offer one value and hold it until accepted; then maybe pause
  task automatic offer_value(input logic signed [itoa_pkg::VALUE_W-1:0] num,
                             input string text);
    strings_typed.push_back(text);
    item_valid <= 1'b1;
    value <= num;
    do @(posedge clk); while (item_stall);
    items_taken++;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Write the radix once every string in flight has drained
  task automatic set_radix(input logic [itoa_pkg::RADIX_W-1:0] base);
    item_valid <= 1'b0;
    while (strings_done != items_taken || item_stall) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    radix <= base;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : drive_stimulus
    plan_row_t                    rows[23];
    int                           corner_values[4];
    int                           num;
    logic [itoa_pkg::RADIX_W-1:0] base;
    rows = '{
      '{itoa_pkg::RADIX_DEC, 0,      "0"},
      '{itoa_pkg::RADIX_DEC, 65535,  "65535"},
      '{itoa_pkg::RADIX_DEC, -65535, "-65535"},
      '{itoa_pkg::RADIX_DEC, -1,     "-1"},
      '{itoa_pkg::RADIX_DEC, -65536, "-0"},
      '{itoa_pkg::RADIX_DEC, 12345,  ""},
      '{itoa_pkg::RADIX_DEC, -407,   ""},
      '{itoa_pkg::RADIX_MIN, 0,      "0"},
      '{itoa_pkg::RADIX_MIN, 65535,  "1111111111111111"},
      '{itoa_pkg::RADIX_MIN, -65535, "1111111111111111"},
      '{itoa_pkg::RADIX_MIN, -65536, "0"},
      '{itoa_pkg::RADIX_MIN, -6,     "110"},
      '{6'd16,               65535,  "FFFF"},
      '{6'd16,               -43981, "ABCD"},
      '{6'd16,               4660,   ""},
      '{itoa_pkg::RADIX_MAX, 65535,  "1VVV"},
      '{itoa_pkg::RADIX_MAX, 31,     "V"},
      '{itoa_pkg::RADIX_MAX, 32,     "10"},
      '{itoa_pkg::RADIX_MAX, -65536, "0"},
      '{6'd3,                65535,  ""},
      '{6'd11,               10,     "A"},
      '{6'd7,                -100,   ""},
      '{itoa_pkg::RADIX_DEC, 1,      "1"}
    };
    corner_values = '{65535, -65535, 0, -1};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows, first ones under the reset radix
    stall_odds = 4;
    gap_odds = 3;
    foreach (rows[i]) begin
      if (rows[i].base != radix) begin
        set_radix(rows[i].base);
      end
      offer_value(itoa_pkg::VALUE_W'(rows[i].num), rows[i].text);
    end

    // Random phases: both extremes of the radix first, then decimal, then random ones
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          base = itoa_pkg::RADIX_MIN;
        end
        1: begin
          base = itoa_pkg::RADIX_MAX;
        end
        2: begin
          base = itoa_pkg::RADIX_DEC;
        end
        default: begin
          base = itoa_pkg::RADIX_W'($urandom_range(itoa_pkg::RADIX_MIN,
                                                   itoa_pkg::RADIX_MAX));
        end
      endcase
      set_radix(base);
      // every third phase runs without idling, and so does the last
      if (p % 3 == 2 || p == RANDOM_PHASES - 1) begin
        stall_odds = 0;
        gap_odds = 0;
      end else begin
        stall_odds = $urandom_range(2, 6);
        gap_odds = $urandom_range(2, 6);
      end
      repeat (PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            num = int'($urandom_range(0, 131070)) - 65535;
          end
          6, 7: begin
            num = int'($urandom_range(0, 80)) - 40;
          end
          8: begin
            num = corner_values[$urandom_range(0, 3)];
          end
          default: begin
            num = (1 << $urandom_range(0, 15)) - int'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1) begin
              num = -num;
            end
          end
        endcase
        offer_value(itoa_pkg::VALUE_W'(num), "");
      end
    end

    // Drain, then give stray beats time to show up
    item_valid <= 1'b0;
    while (strings_done != items_taken) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (chars_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected characters never arrived", $time, chars_due.size());
    end
    if (errors == 0) begin
      $display("integer_to_ascii_digits_test: done, clean");
    end else begin
      $display("integer_to_ascii_digits_test: done, errors");
    end
    $finish;
  end

endmodule
